>>> src/bog_pkg.sv
// shared types and codes for the buffer ownership guard
package bog_pkg;

  localparam int MaxAttachmentsDef = 8;
  localparam int CountBitsDef      = 16;

  // ownership state codes
  localparam logic [2:0] ST_HOST       = 3'd0;
  localparam logic [2:0] ST_TRANSITION = 3'd1;
  localparam logic [2:0] ST_LENT       = 3'd2;
  localparam logic [2:0] ST_ACTIVE     = 3'd3;
  localparam logic [2:0] ST_DETACHED   = 3'd4;
  localparam logic [2:0] ST_RECLAIMED  = 3'd5;
  localparam logic [2:0] ST_POISONED   = 3'd6;

  // owner kind codes
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_EXTERNAL = 2'd1;
  localparam logic [1:0] KIND_INTERNAL = 2'd2;

  typedef enum logic [4:0] {
    OP_LEND          = 5'd0,
    OP_TRANSFER_DONE = 5'd1,
    OP_MARK_ACTIVE   = 5'd2,
    OP_MARK_DETACHED = 5'd3,
    OP_RECLAIM       = 5'd4,
    OP_CPU_BEGIN     = 5'd5,
    OP_CPU_END       = 5'd6,
    OP_USER_MAP      = 5'd7,
    OP_VMA_OPEN      = 5'd8,
    OP_VMA_CLOSE     = 5'd9,
    OP_KMAP          = 5'd10,
    OP_KUNMAP        = 5'd11,
    OP_DEV_MAP       = 5'd12,
    OP_DEV_UNMAP     = 5'd13,
    OP_DETACH        = 5'd14,
    OP_QUERY         = 5'd15,
    OP_RELEASE       = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_PERM  = 2'd1,
    STS_BUSY  = 2'd2,
    STS_OWNER = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0] operation;
    logic       cam_grant;
    logic       outcome_ok;
    logic [2:0] attachment;
  } event_t;

  typedef struct packed {
    logic [2:0] owner_state;
    logic       hold_flag;
    logic [1:0] owner_kind;
    logic       pending_is_lend;
  } ctrl_t;

  typedef struct packed {
    status_e    status;
    logic       is_protected;
    logic       skip_cpu_sync;
    logic       shared_attr;
    logic [2:0] state_now;
  } result_t;

endpackage

>>> src/buffer_ownership_guard_unit.sv
// top level of the buffer ownership guard
//
// usage:
//   one event per input transaction (operation, cam_grant, outcome_ok,
//   attachment) on a valid/ready channel; one result per event (status,
//   is_protected, skip_cpu_sync, shared_attr, state_now) on a valid/ready
//   output channel, in event order; the user must write shared_mode
//   through cfg_we_i/cfg_wdata_i while the block idles (unenforced)
// flow:
//   an event sits in the input register while the ownership logic
//   evaluates it; the result register loads it once it has space;
//   one event per cycle is sustained while out_ready_i stays high, set
//   by the single ownership-state update done per retired event
// reset:
//   asynchronous, active low; clears both pipeline valids, the ownership
//   state, counters, slot bitmap and shared_mode
// stall:
//   while the receiver holds out_ready_i low the result register keeps its
//   transaction, the input register holds one more, and in_ready_o drops
//   once both are full
module buffer_ownership_guard_unit #(
  parameter int MAX_ATTACHMENTS = bog_pkg::MaxAttachmentsDef,
  parameter int COUNT_BITS      = bog_pkg::CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // event channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] operation_i,
  input  logic       cam_grant_i,
  input  logic       outcome_ok_i,
  input  logic [2:0] attachment_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       is_protected_o,
  output logic       skip_cpu_sync_o,
  output logic       shared_attr_o,
  output logic [2:0] state_now_o
);

  bog_pkg::event_t  ev_in;
  bog_pkg::event_t  ev_cur;
  logic             ev_valid;
  logic             out_space;
  logic             advance;
  bog_pkg::result_t res_d;
  bog_pkg::result_t res_q;

  // ownership state
  logic                       shared_mode_q;
  bog_pkg::ctrl_t             ctrl_q, ctrl_d;
  logic [COUNT_BITS-1:0]      user_cnt_q, user_cnt_d;
  logic [COUNT_BITS-1:0]      kern_cnt_q, kern_cnt_d;
  logic [COUNT_BITS-1:0]      cpu_cnt_q, cpu_cnt_d;
  logic [MAX_ATTACHMENTS-1:0] slots_q, slots_d;

  assign ev_in.operation  = operation_i;
  assign ev_in.cam_grant  = cam_grant_i;
  assign ev_in.outcome_ok = outcome_ok_i;
  assign ev_in.attachment = attachment_i;

  // an event is evaluated and retired when the result register has room
  assign advance = ev_valid && out_space;

  bog_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ev_i       (ev_in),
    .take_i     (out_space),
    .valid_o    (ev_valid),
    .ev_o       (ev_cur)
  );

  bog_event_logic #(
    .MAX_ATTACHMENTS (MAX_ATTACHMENTS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_event_logic (
    .ev_i          (ev_cur),
    .shared_mode_i (shared_mode_q),
    .ctrl_i        (ctrl_q),
    .user_cnt_i    (user_cnt_q),
    .kern_cnt_i    (kern_cnt_q),
    .cpu_cnt_i     (cpu_cnt_q),
    .slots_i       (slots_q),
    .ctrl_o        (ctrl_d),
    .user_cnt_o    (user_cnt_d),
    .kern_cnt_o    (kern_cnt_d),
    .cpu_cnt_o     (cpu_cnt_d),
    .slots_o       (slots_d),
    .res_o         (res_d)
  );

  // state commits together with the result load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.owner_state     <= bog_pkg::ST_HOST;
      ctrl_q.hold_flag       <= 1'b0;
      ctrl_q.owner_kind      <= bog_pkg::KIND_NONE;
      ctrl_q.pending_is_lend <= 1'b0;
      user_cnt_q <= '0;
      kern_cnt_q <= '0;
      cpu_cnt_q  <= '0;
      slots_q    <= '0;
    end else if (advance) begin
      ctrl_q     <= ctrl_d;
      user_cnt_q <= user_cnt_d;
      kern_cnt_q <= kern_cnt_d;
      cpu_cnt_q  <= cpu_cnt_d;
      slots_q    <= slots_d;
    end
  end

  // config register, survives release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      shared_mode_q <= cfg_wdata_i;
    end
  end

  bog_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res_d),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign status_o        = res_q.status;
  assign is_protected_o  = res_q.is_protected;
  assign skip_cpu_sync_o = res_q.skip_cpu_sync;
  assign shared_attr_o   = res_q.shared_attr;
  assign state_now_o     = res_q.state_now;

endmodule

>>> src/bog_in_reg.sv
// input register stage holding one event transaction
module bog_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bog_pkg::event_t ev_i,
  input  logic            take_i,
  output logic            valid_o,
  output bog_pkg::event_t ev_o
);

  logic            valid_q;
  bog_pkg::event_t ev_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign ev_o       = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ev_q <= ev_i;
    end
  end

endmodule

>>> src/bog_event_logic.sv
// next-state and result logic for one ownership event
module bog_event_logic #(
  parameter int MAX_ATTACHMENTS = bog_pkg::MaxAttachmentsDef,
  parameter int COUNT_BITS      = bog_pkg::CountBitsDef
) (
  input  bog_pkg::event_t         ev_i,
  input  logic                    shared_mode_i,
  input  bog_pkg::ctrl_t          ctrl_i,
  input  logic [COUNT_BITS-1:0]   user_cnt_i,
  input  logic [COUNT_BITS-1:0]   kern_cnt_i,
  input  logic [COUNT_BITS-1:0]   cpu_cnt_i,
  input  logic [MAX_ATTACHMENTS-1:0] slots_i,
  output bog_pkg::ctrl_t          ctrl_o,
  output logic [COUNT_BITS-1:0]   user_cnt_o,
  output logic [COUNT_BITS-1:0]   kern_cnt_o,
  output logic [COUNT_BITS-1:0]   cpu_cnt_o,
  output logic [MAX_ATTACHMENTS-1:0] slots_o,
  output bog_pkg::result_t        res_o
);

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_down(input logic [COUNT_BITS-1:0] c);
    return (c == '0) ? c : c - COUNT_BITS'(1);
  endfunction

  logic                       host_owns;
  logic                       busy;
  logic                       slot_valid;
  logic [MAX_ATTACHMENTS-1:0] slot_mask;
  bog_pkg::status_e           status;
  logic [2:0]                 st;

  assign st = ctrl_i.owner_state;
  assign host_owns = (st == bog_pkg::ST_HOST) || (st == bog_pkg::ST_RECLAIMED);
  assign busy = (|user_cnt_i) || (|kern_cnt_i) || (|cpu_cnt_i) || (|slots_i);
  assign slot_valid = int'(ev_i.attachment) < MAX_ATTACHMENTS;

  always_comb begin
    for (int i = 0; i < MAX_ATTACHMENTS; i++) begin
      slot_mask[i] = (int'(ev_i.attachment) == i);
    end
  end

  always_comb begin
    ctrl_o     = ctrl_i;
    user_cnt_o = user_cnt_i;
    kern_cnt_o = kern_cnt_i;
    cpu_cnt_o  = cpu_cnt_i;
    slots_o    = slots_i;
    status     = bog_pkg::STS_OK;
    res_o.skip_cpu_sync = 1'b0;
    res_o.shared_attr   = 1'b0;

    unique case (ev_i.operation)
      bog_pkg::OP_LEND: begin
        if (!host_owns || ctrl_i.hold_flag) begin
          status = bog_pkg::STS_PERM;
        end else if (busy) begin
          status = bog_pkg::STS_BUSY;
        end else begin
          ctrl_o.hold_flag       = 1'b1;
          ctrl_o.owner_state     = bog_pkg::ST_TRANSITION;
          ctrl_o.owner_kind      = ev_i.cam_grant ? bog_pkg::KIND_INTERNAL
                                                  : bog_pkg::KIND_EXTERNAL;
          ctrl_o.pending_is_lend = 1'b1;
        end
      end
      bog_pkg::OP_TRANSFER_DONE: begin
        if (st != bog_pkg::ST_TRANSITION) begin
          status = bog_pkg::STS_PERM;
        end else if (!ev_i.outcome_ok) begin
          ctrl_o.owner_state = bog_pkg::ST_POISONED;
          status = bog_pkg::STS_PERM;
        end else if (ctrl_i.pending_is_lend) begin
          ctrl_o.owner_state = bog_pkg::ST_LENT;
        end else begin
          ctrl_o.owner_state = bog_pkg::ST_RECLAIMED;
          ctrl_o.owner_kind  = bog_pkg::KIND_NONE;
          ctrl_o.hold_flag   = 1'b0;
        end
      end
      bog_pkg::OP_MARK_ACTIVE: begin
        if (st != bog_pkg::ST_LENT || !ctrl_i.hold_flag) begin
          status = bog_pkg::STS_PERM;
        end else begin
          ctrl_o.owner_state = bog_pkg::ST_ACTIVE;
        end
      end
      bog_pkg::OP_MARK_DETACHED: begin
        if (st != bog_pkg::ST_ACTIVE || !ctrl_i.hold_flag) begin
          status = bog_pkg::STS_PERM;
        end else begin
          ctrl_o.owner_state = bog_pkg::ST_DETACHED;
        end
      end
      bog_pkg::OP_RECLAIM: begin
        if (!ctrl_i.hold_flag ||
            (st != bog_pkg::ST_DETACHED && st != bog_pkg::ST_LENT)) begin
          status = bog_pkg::STS_PERM;
        end else if (ctrl_i.owner_kind != bog_pkg::KIND_INTERNAL &&
                     ctrl_i.owner_kind != bog_pkg::KIND_EXTERNAL) begin
          status = bog_pkg::STS_OWNER;
        end else begin
          ctrl_o.owner_state     = bog_pkg::ST_TRANSITION;
          ctrl_o.pending_is_lend = 1'b0;
        end
      end
      bog_pkg::OP_CPU_BEGIN: begin
        if (!host_owns) begin
          status = bog_pkg::STS_PERM;
        end else begin
          cpu_cnt_o = count_up(cpu_cnt_i);
        end
      end
      bog_pkg::OP_CPU_END: begin
        if (!host_owns || cpu_cnt_i == '0) begin
          status = bog_pkg::STS_PERM;
        end else begin
          cpu_cnt_o = count_down(cpu_cnt_i);
        end
      end
      bog_pkg::OP_USER_MAP: begin
        if (!host_owns || !ev_i.outcome_ok) begin
          status = bog_pkg::STS_PERM;
        end else begin
          user_cnt_o = count_up(user_cnt_i);
        end
      end
      bog_pkg::OP_VMA_OPEN: begin
        user_cnt_o = count_up(user_cnt_i);
      end
      bog_pkg::OP_VMA_CLOSE: begin
        user_cnt_o = count_down(user_cnt_i);
      end
      bog_pkg::OP_KMAP: begin
        if (!host_owns) begin
          status = bog_pkg::STS_PERM;
        end else if (kern_cnt_i != '0) begin
          kern_cnt_o = count_up(kern_cnt_i);
        end else if (ev_i.outcome_ok) begin
          kern_cnt_o = COUNT_BITS'(1);
        end else begin
          status = bog_pkg::STS_PERM;
        end
      end
      bog_pkg::OP_KUNMAP: begin
        kern_cnt_o = count_down(kern_cnt_i);
      end
      bog_pkg::OP_DEV_MAP: begin
        res_o.skip_cpu_sync = !host_owns;
        res_o.shared_attr   = shared_mode_i;
        if (!slot_valid || !ev_i.outcome_ok) begin
          status = bog_pkg::STS_PERM;
        end else begin
          slots_o = slots_i | slot_mask;
        end
      end
      bog_pkg::OP_DEV_UNMAP: begin
        res_o.skip_cpu_sync = !host_owns;
        res_o.shared_attr   = shared_mode_i;
        if (!slot_valid) begin
          status = bog_pkg::STS_PERM;
        end else begin
          slots_o = slots_i & ~slot_mask;
        end
      end
      bog_pkg::OP_DETACH: begin
        if (!slot_valid) begin
          status = bog_pkg::STS_PERM;
        end else begin
          slots_o = slots_i & ~slot_mask;
        end
      end
      bog_pkg::OP_QUERY: begin
        status = bog_pkg::STS_OK;
      end
      bog_pkg::OP_RELEASE: begin
        if (!host_owns || ctrl_i.hold_flag) begin
          status = bog_pkg::STS_PERM;
        end else begin
          ctrl_o.owner_state     = bog_pkg::ST_HOST;
          ctrl_o.hold_flag       = 1'b0;
          ctrl_o.owner_kind      = bog_pkg::KIND_NONE;
          ctrl_o.pending_is_lend = 1'b0;
          user_cnt_o = '0;
          kern_cnt_o = '0;
          cpu_cnt_o  = '0;
          slots_o    = '0;
        end
      end
      default: begin
        status = bog_pkg::STS_PERM;
      end
    endcase

    res_o.status       = status;
    res_o.state_now    = ctrl_o.owner_state;
    res_o.is_protected = (ctrl_o.owner_state != bog_pkg::ST_HOST) &&
                         (ctrl_o.owner_state != bog_pkg::ST_RECLAIMED);
  end

endmodule

>>> src/bog_out_reg.sv
// result register stage holding one result transaction
module bog_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bog_pkg::result_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bog_pkg::result_t res_o
);

  logic             valid_q;
  bog_pkg::result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> src/bog_checker.sv
// port-level checks for the buffer ownership guard, bound to the top level
module bog_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [4:0] operation_i,
  input logic       cam_grant_i,
  input logic       outcome_ok_i,
  input logic [2:0] attachment_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic       is_protected_o,
  input logic       skip_cpu_sync_o,
  input logic       shared_attr_o,
  input logic [2:0] state_now_o
);

  // a stalled result keeps its transaction
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(state_now_o))
    else $error("result changed while stalled");

  // protection flag follows the reported state
  a_protect_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_protected_o ==
      ((state_now_o != bog_pkg::ST_HOST) && (state_now_o != bog_pkg::ST_RECLAIMED))))
    else $error("is_protected disagrees with state_now");

  // no state code beyond poisoned
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_now_o <= bog_pkg::ST_POISONED))
    else $error("state_now out of range");

  // device ops keep the state, so a cache-sync skip means a protected buffer
  a_skip_protected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skip_cpu_sync_o |-> is_protected_o)
    else $error("skip_cpu_sync while host owns the buffer");

endmodule

bind buffer_ownership_guard_unit bog_checker u_bog_checker (.*);
